// ===== rtl/bbvn_pkg.sv =====
package bbvn_pkg;

  localparam int unsigned MaxVertices = 1024;
  localparam int unsigned CoordW = 32;
  localparam int unsigned NormW = 17;
  localparam int unsigned IdxW = 10;
  localparam int unsigned StatW = 3;
  localparam int unsigned ExtW = 33;
  localparam int unsigned NumAxes = 3;

  typedef enum logic [1:0] {
    FuncLoad  = 2'd0,
    FuncRead  = 2'd1,
    FuncClear = 2'd2,
    FuncNone  = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    StAccepted = 3'd0,
    StFull     = 3'd1,
    StNorm     = 3'd2,
    StZeroExt  = 3'd3,
    StEmpty    = 3'd4
  } status_e;

  typedef struct packed {
    logic            start;
    logic [ExtW+1:0] mag;
    logic [ExtW-1:0] ext;
  } div_req_t;

endpackage

// ===== rtl/bbvn_div_lane.sv =====
module bbvn_div_lane (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  bbvn_pkg::div_req_t                   req_i,
  output logic                                 done_o,
  output logic [bbvn_pkg::NormW-1:0]           quot_o
);
  import bbvn_pkg::*;

  // Numerator is (mag << 16) + ext, divisor is 2*ext; quotient saturates at 32768.
  localparam int unsigned NumW = ExtW + 2 + 16 + 1;
  localparam int unsigned DenW = ExtW + 1;
  localparam int unsigned QW = 17;

  logic [NumW-1:0] num_q, num_d;
  logic [DenW:0]   rem_q, rem_d;
  logic [DenW-1:0] den_q;
  logic [5:0]      cnt_q;
  logic            busy_q;
  logic [DenW:0]   trial;

  always_comb begin
    rem_d = {rem_q[DenW-1:0], num_q[NumW-1]};
    num_d = {num_q[NumW-2:0], 1'b0};
    trial = rem_d - {1'b0, den_q};
    if (!trial[DenW]) begin
      rem_d = trial;
      num_d[0] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_o <= 1'b0;
      num_q  <= '0;
      den_q  <= '0;
      rem_q  <= '0;
    end else begin
      done_o <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'(NumW);
        num_q  <= NumW'({req_i.mag, 16'd0}) + NumW'(req_i.ext);
        den_q  <= {req_i.ext, 1'b0};
        rem_q  <= '0;
      end else if (busy_q) begin
        num_q <= num_d;
        rem_q <= rem_d;
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    if (num_q > NumW'(32768)) quot_o = 17'd32768;
    else quot_o = num_q[QW-1:0];
  end
endmodule

// ===== rtl/bounding_box_vertex_normalizer.sv =====
// Load, clear, unused and exhausted read requests go from SIdle straight to SOut.
// A read passes SFetch and SSetup, then SOut if the extent is zero; else three lanes run a
// bit-serial restoring divider of 52 steps in parallel, one per axis, then merge.
// One request is in progress at a time; busy is high until its result strobes.
// Reset is asynchronous and active low; the vertex memory is not cleared.
// The receiver cannot stall: each result's strobe_o is high for exactly one cycle.
module bounding_box_vertex_normalizer #(
  parameter int unsigned MAX_VERTICES = bbvn_pkg::MaxVertices
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        func_i,
  input  logic signed [bbvn_pkg::CoordW-1:0] coord_x_i,
  input  logic signed [bbvn_pkg::CoordW-1:0] coord_y_i,
  input  logic signed [bbvn_pkg::CoordW-1:0] coord_z_i,
  output logic                              strobe_o,
  output logic [bbvn_pkg::StatW-1:0]        status_o,
  output logic signed [bbvn_pkg::NormW-1:0] norm_x_o,
  output logic signed [bbvn_pkg::NormW-1:0] norm_y_o,
  output logic signed [bbvn_pkg::NormW-1:0] norm_z_o,
  output logic [bbvn_pkg::IdxW-1:0]         vertex_index_o,
  output logic                              is_last_o
);
  import bbvn_pkg::*;

  localparam int unsigned AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int unsigned CW = $clog2(MAX_VERTICES + 1);

  typedef enum logic [2:0] {SIdle, SFetch, SSetup, SDiv, SOut} state_e;

  state_e state_q;
  logic [3*CoordW-1:0] mem [MAX_VERTICES];
  logic [3*CoordW-1:0] rd_q;
  logic signed [CoordW-1:0] min_q [NumAxes];
  logic signed [CoordW-1:0] max_q [NumAxes];
  logic [CW-1:0] cnt_q, rp_q;
  logic [ExtW-1:0] ext_q;
  logic reading_q;
  logic neg_q [NumAxes];
  logic [NumAxes-1:0] done;
  logic [NormW-1:0] quot [NumAxes];
  div_req_t req [NumAxes];
  logic signed [CoordW-1:0] in_c [NumAxes];
  logic signed [CoordW:0] sum_c [NumAxes];
  logic signed [ExtW-1:0] ext_c [NumAxes];
  logic [ExtW-1:0] ext_max;
  logic signed [ExtW+1:0] dd [NumAxes];
  logic [CW-1:0] rp_use;

  assign in_c[0] = coord_x_i;
  assign in_c[1] = coord_y_i;
  assign in_c[2] = coord_z_i;
  assign rp_use = reading_q ? rp_q : '0;

  always_comb begin
    ext_max = '0;
    for (int i = 0; i < NumAxes; i++) begin
      sum_c[i] = {min_q[i][CoordW-1], min_q[i]} + {max_q[i][CoordW-1], max_q[i]};
      ext_c[i] = {max_q[i][CoordW-1], max_q[i]} - {min_q[i][CoordW-1], min_q[i]};
      if (cnt_q != '0 && $unsigned(ext_c[i]) > ext_max) ext_max = ext_c[i];
      dd[i] = {rd_q[i*CoordW+CoordW-1], rd_q[i*CoordW+CoordW-1], rd_q[i*CoordW +: CoordW],
               1'b0}
              - {sum_c[i][CoordW], sum_c[i][CoordW], sum_c[i]};
    end
  end

  for (genvar g = 0; g < NumAxes; g++) begin : g_lane
    always_comb begin
      req[g].start = (state_q == SSetup) && (ext_q != '0);
      req[g].mag   = dd[g][ExtW+1] ? (ExtW+2)'(-dd[g]) : (ExtW+2)'(dd[g]);
      req[g].ext   = ext_q;
    end
    bbvn_div_lane u_lane (
      .clk_i, .rst_ni, .req_i(req[g]), .done_o(done[g]), .quot_o(quot[g])
    );
  end

  always_ff @(posedge clk_i) begin
    if (state_q == SIdle && start && func_e'(func_i) == FuncLoad && cnt_q < CW'(MAX_VERTICES))
      mem[cnt_q[AW-1:0]] <= {coord_z_i, coord_y_i, coord_x_i};
    rd_q <= mem[rp_use[AW-1:0]];
  end

  function automatic logic [NormW-1:0] sgn(input logic n, input logic [NormW-1:0] q);
    return n ? -q : q;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      strobe_o <= 1'b0;
      status_o <= '0;
      norm_x_o <= '0;
      norm_y_o <= '0;
      norm_z_o <= '0;
      vertex_index_o <= '0;
      is_last_o <= 1'b0;
      cnt_q <= '0;
      rp_q <= '0;
      ext_q <= '0;
      reading_q <= 1'b0;
      for (int i = 0; i < NumAxes; i++) begin
        min_q[i] <= {1'b0, {(CoordW-1){1'b1}}};
        max_q[i] <= {1'b1, {(CoordW-1){1'b0}}};
        neg_q[i] <= 1'b0;
      end
    end else begin
      strobe_o <= 1'b0;
      case (state_q)
        SIdle: begin
          if (start) begin
            status_o <= StEmpty;
            norm_x_o <= '0;
            norm_y_o <= '0;
            norm_z_o <= '0;
            vertex_index_o <= '0;
            is_last_o <= 1'b0;
            state_q <= SOut;
            case (func_e'(func_i))
              FuncLoad: begin
                reading_q <= 1'b0;
                if (cnt_q >= CW'(MAX_VERTICES)) begin
                  status_o <= StFull;
                end else begin
                  status_o <= StAccepted;
                  cnt_q <= cnt_q + 1'b1;
                  for (int i = 0; i < NumAxes; i++) begin
                    if (in_c[i] < min_q[i]) min_q[i] <= in_c[i];
                    if (in_c[i] > max_q[i]) max_q[i] <= in_c[i];
                  end
                end
              end
              FuncRead: begin
                if (!reading_q) begin
                  reading_q <= 1'b1;
                  rp_q <= '0;
                  ext_q <= ext_max;
                end
                if (rp_use < cnt_q) state_q <= SFetch;
              end
              FuncClear: begin
                status_o <= StAccepted;
                cnt_q <= '0;
                rp_q <= '0;
                ext_q <= '0;
                reading_q <= 1'b0;
                for (int i = 0; i < NumAxes; i++) begin
                  min_q[i] <= {1'b0, {(CoordW-1){1'b1}}};
                  max_q[i] <= {1'b1, {(CoordW-1){1'b0}}};
                end
              end
              default: ;
            endcase
          end
        end
        SFetch: state_q <= SSetup;
        SSetup: begin
          vertex_index_o <= rp_q[IdxW-1:0];
          is_last_o <= (rp_q + 1'b1 == cnt_q);
          rp_q <= rp_q + 1'b1;
          for (int i = 0; i < NumAxes; i++) neg_q[i] <= dd[i][ExtW+1];
          if (ext_q == '0) begin
            status_o <= StZeroExt;
            state_q <= SOut;
          end else begin
            status_o <= StNorm;
            state_q <= SDiv;
          end
        end
        SDiv: begin
          if (&done) begin
            norm_x_o <= sgn(neg_q[0], quot[0]);
            norm_y_o <= sgn(neg_q[1], quot[1]);
            norm_z_o <= sgn(neg_q[2], quot[2]);
            state_q <= SOut;
          end
        end
        SOut: begin
          strobe_o <= 1'b1;
          state_q <= SIdle;
        end
        default: state_q <= SIdle;
      endcase
    end
  end

  assign busy = (state_q != SIdle);
endmodule
